FILE: rtl/command_line_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// command line tokenizer assertion macros
// shared concurrent assertion forms for the tokenizer modules
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH

// generic form with explicit clock and active-low reset
`define CLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// form bound to the house clock and reset names
`define CLT_ASSERT_CLK(lbl, prop, msg) \
  `CLT_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// types and constants shared by the command line tokenizer modules
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  typedef enum logic [2:0] {
    EV_NAME_CHAR = 3'd0,
    EV_NAME_END  = 3'd1,
    EV_ARG_CHAR  = 3'd2,
    EV_ARG_END   = 3'd3,
    EV_CMD_END   = 3'd4,
    EV_ERROR     = 3'd5
  } ev_kind_e;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_NAME   = 3'd1,
    ST_LIST   = 3'd2,
    ST_WORD   = 3'd3,
    ST_STRING = 3'd4
  } parse_state_e;

  // error codes
  localparam logic [2:0] ERR_BAD_START   = 3'd0;
  localparam logic [2:0] ERR_BAD_NAME    = 3'd1;
  localparam logic [2:0] ERR_COMMA_END   = 3'd2;
  localparam logic [2:0] ERR_DUP_COMMA   = 3'd3;
  localparam logic [2:0] ERR_NEED_COMMA  = 3'd4;
  localparam logic [2:0] ERR_BAD_LIST    = 3'd5;
  localparam logic [2:0] ERR_NONE        = 3'd0;

  // escape modes, hex modes equal their digit count
  localparam logic [3:0] ESC_NONE  = 4'd0;
  localparam logic [3:0] ESC_SLASH = 4'd1;
  localparam logic [3:0] ESC_HEX2  = 4'd2;
  localparam logic [3:0] ESC_OCT   = 4'd3;
  localparam logic [3:0] ESC_HEX4  = 4'd4;
  localparam logic [3:0] ESC_HEX8  = 4'd8;
  localparam logic [3:0] OCT_DIGITS = 4'd3;

  localparam int unsigned CharW = 21;

  localparam logic [CharW-1:0] CH_SEMI   = CharW'(8'h3B);
  localparam logic [CharW-1:0] CH_COMMA  = CharW'(8'h2C);
  localparam logic [CharW-1:0] CH_BSLASH = CharW'(8'h5C);
  localparam logic [CharW-1:0] CH_LOW_X  = CharW'(8'h78);
  localparam logic [CharW-1:0] CH_LOW_U  = CharW'(8'h75);
  localparam logic [CharW-1:0] CH_UP_U   = CharW'(8'h55);
  localparam logic [CharW-1:0] CH_DQUOTE = CharW'(8'h22);
  localparam logic [CharW-1:0] CH_SQUOTE = CharW'(8'h27);
  localparam logic [CharW-1:0] CH_ZERO   = CharW'(8'h30);
  localparam logic [CharW-1:0] CH_SEVEN  = CharW'(8'h37);

  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] value;
    logic [2:0]  err;
  } event_t;

  // all events caused by one character, cnt is 1 or 2 when queued
  typedef struct packed {
    logic [1:0] cnt;
    event_t     ev0;
    event_t     ev1;
  } bundle_t;

endpackage

`default_nettype wire

FILE: rtl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// parses one character per cycle unless the queue is full and queues its events
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_line_tokenizer_unit_macros.svh"

module clt_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [clt_pkg::CharW-1:0]      char_code_i,
  input  wire logic                           q_full_i,
  output logic                                push_o,
  output clt_pkg::bundle_t                    bundle_o
);

  typedef struct packed {
    clt_pkg::parse_state_e pstate;
    logic                  vpend;
    logic                  aseen;
    logic                  qdbl;
    logic [3:0]            esc_mode;
    logic [3:0]            esc_digits;
    logic [31:0]           esc_value;
  } ctx_t;

  typedef struct packed {
    ctx_t             nx;
    clt_pkg::bundle_t b;
  } step_t;

  localparam ctx_t CTX_RESET = '{pstate: clt_pkg::ST_START, vpend: 1'b0, aseen: 1'b0,
                                 qdbl: 1'b0, esc_mode: clt_pkg::ESC_NONE,
                                 esc_digits: 4'd0, esc_value: 32'd0};

  ctx_t  ctx_q, ctx_d;
  step_t res;
  logic  accept;

  function automatic logic is_space(logic [clt_pkg::CharW-1:0] c);
    return c == 21'h20 || c == 21'h09 || c == 21'h0D || c == 21'h0A;
  endfunction

  function automatic logic is_word(logic [clt_pkg::CharW-1:0] c);
    return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
           (c >= 21'h30 && c <= 21'h39) || c == 21'h5F;
  endfunction

  function automatic logic [4:0] hex_digit(logic [clt_pkg::CharW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 21'h30 && c <= 21'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [31:0] simple_escape(logic [clt_pkg::CharW-1:0] c);
    logic [31:0] r;
    r = 32'(c);
    case (c)
      21'h61:  r = 32'd7;
      21'h62:  r = 32'd8;
      21'h66:  r = 32'd12;
      21'h6E:  r = 32'd10;
      21'h72:  r = 32'd13;
      21'h74:  r = 32'd9;
      21'h76:  r = 32'd11;
      default: r = 32'(c);
    endcase
    return r;
  endfunction

  function automatic clt_pkg::bundle_t add_ev(clt_pkg::bundle_t b, clt_pkg::ev_kind_e k,
                                              logic [31:0] v, logic [2:0] e);
    clt_pkg::bundle_t r;
    r = b;
    if (b.cnt == 2'd0) begin
      r.ev0 = '{kind: k, value: v, err: e};
      r.cnt = 2'd1;
    end else begin
      r.ev1 = '{kind: k, value: v, err: e};
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  // argument list handling, also entered when a word ends
  function automatic step_t list_step(ctx_t s, logic [clt_pkg::CharW-1:0] c,
                                      clt_pkg::bundle_t b);
    step_t r;
    r.nx = s;
    r.b  = b;
    if (c == clt_pkg::CH_SEMI) begin
      if (s.vpend || !s.aseen) begin
        if (s.vpend) begin
          r.b = add_ev(r.b, clt_pkg::EV_ARG_END, 32'd0, clt_pkg::ERR_NONE);
        end
        r.nx = CTX_RESET;
        r.b  = add_ev(r.b, clt_pkg::EV_CMD_END, 32'd0, clt_pkg::ERR_NONE);
      end else begin
        r.nx = CTX_RESET;
        r.b  = add_ev(r.b, clt_pkg::EV_ERROR, 32'd0, clt_pkg::ERR_COMMA_END);
      end
    end else if (c == clt_pkg::CH_COMMA) begin
      if (s.vpend) begin
        r.b        = add_ev(r.b, clt_pkg::EV_ARG_END, 32'd0, clt_pkg::ERR_NONE);
        r.nx.vpend = 1'b0;
        r.nx.aseen = 1'b1;
      end else begin
        r.nx = CTX_RESET;
        r.b  = add_ev(r.b, clt_pkg::EV_ERROR, 32'd0, clt_pkg::ERR_DUP_COMMA);
      end
    end else if (is_space(c)) begin
      r.nx = s;
    end else if (s.vpend) begin
      r.nx = CTX_RESET;
      r.b  = add_ev(r.b, clt_pkg::EV_ERROR, 32'd0, clt_pkg::ERR_NEED_COMMA);
    end else if (c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_SQUOTE) begin
      r.nx.vpend      = 1'b1;
      r.nx.qdbl       = (c == clt_pkg::CH_DQUOTE);
      r.nx.esc_mode   = clt_pkg::ESC_NONE;
      r.nx.esc_digits = 4'd0;
      r.nx.esc_value  = 32'd0;
      r.nx.pstate     = clt_pkg::ST_STRING;
    end else if (is_word(c)) begin
      r.nx.vpend  = 1'b1;
      r.nx.pstate = clt_pkg::ST_WORD;
      r.b         = add_ev(r.b, clt_pkg::EV_ARG_CHAR, 32'(c), clt_pkg::ERR_NONE);
    end else begin
      r.nx = CTX_RESET;
      r.b  = add_ev(r.b, clt_pkg::EV_ERROR, 32'd0, clt_pkg::ERR_BAD_LIST);
    end
    return r;
  endfunction

  function automatic step_t string_step(ctx_t s, logic [clt_pkg::CharW-1:0] c);
    step_t      r;
    logic       plain;
    logic [4:0] hd;
    logic [3:0] dn;
    r.nx  = s;
    r.b   = '0;
    plain = 1'b0;
    hd    = hex_digit(c);
    dn    = s.esc_digits + 4'd1;
    if (s.esc_mode == clt_pkg::ESC_OCT) begin
      if (c >= clt_pkg::CH_ZERO && c <= clt_pkg::CH_SEVEN) begin
        r.nx.esc_value  = {s.esc_value[28:0], c[2:0]};
        r.nx.esc_digits = dn;
        if (dn >= clt_pkg::OCT_DIGITS) begin
          r.b           = add_ev(r.b, clt_pkg::EV_ARG_CHAR, r.nx.esc_value, clt_pkg::ERR_NONE);
          r.nx.esc_mode = clt_pkg::ESC_NONE;
        end
      end else begin
        r.b           = add_ev(r.b, clt_pkg::EV_ARG_CHAR, s.esc_value, clt_pkg::ERR_NONE);
        r.nx.esc_mode = clt_pkg::ESC_NONE;
        plain         = 1'b1;
      end
    end else if (s.esc_mode >= clt_pkg::ESC_HEX2) begin
      if (hd[4]) begin
        r.nx.esc_value  = {s.esc_value[27:0], hd[3:0]};
        r.nx.esc_digits = dn;
        if (dn >= s.esc_mode) begin
          r.b           = add_ev(r.b, clt_pkg::EV_ARG_CHAR, r.nx.esc_value, clt_pkg::ERR_NONE);
          r.nx.esc_mode = clt_pkg::ESC_NONE;
        end
      end else begin
        r.b           = add_ev(r.b, clt_pkg::EV_ARG_CHAR, s.esc_value, clt_pkg::ERR_NONE);
        r.nx.esc_mode = clt_pkg::ESC_NONE;
        plain         = 1'b1;
      end
    end else if (s.esc_mode == clt_pkg::ESC_SLASH) begin
      r.nx.esc_digits = 4'd0;
      r.nx.esc_value  = 32'd0;
      if (c >= clt_pkg::CH_ZERO && c <= clt_pkg::CH_SEVEN) begin
        r.nx.esc_mode   = clt_pkg::ESC_OCT;
        r.nx.esc_digits = 4'd1;
        r.nx.esc_value  = 32'(c[2:0]);
      end else if (c == clt_pkg::CH_LOW_X) begin
        r.nx.esc_mode = clt_pkg::ESC_HEX2;
      end else if (c == clt_pkg::CH_LOW_U) begin
        r.nx.esc_mode = clt_pkg::ESC_HEX4;
      end else if (c == clt_pkg::CH_UP_U) begin
        r.nx.esc_mode = clt_pkg::ESC_HEX8;
      end else begin
        r.nx.esc_mode = clt_pkg::ESC_NONE;
        r.b = add_ev(r.b, clt_pkg::EV_ARG_CHAR, simple_escape(c), clt_pkg::ERR_NONE);
      end
    end else begin
      plain = 1'b1;
    end
    // a cut-short escape hands the same character on as a plain one
    if (plain) begin
      if (c == clt_pkg::CH_BSLASH) begin
        r.nx.esc_mode = clt_pkg::ESC_SLASH;
      end else if (c == (s.qdbl ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE)) begin
        r.nx.pstate = clt_pkg::ST_LIST;
      end else begin
        r.b = add_ev(r.b, clt_pkg::EV_ARG_CHAR, 32'(c), clt_pkg::ERR_NONE);
      end
    end
    return r;
  endfunction

  function automatic step_t step(ctx_t s, logic [clt_pkg::CharW-1:0] c);
    step_t r;
    ctx_t  t;
    r.nx = s;
    r.b  = '0;
    t    = s;
    case (s.pstate)
      clt_pkg::ST_START: begin
        if (is_space(c)) begin
          r.nx = s;
        end else if (is_word(c)) begin
          r.nx.pstate = clt_pkg::ST_NAME;
          r.b = add_ev(r.b, clt_pkg::EV_NAME_CHAR, 32'(c), clt_pkg::ERR_NONE);
        end else begin
          r.nx = CTX_RESET;
          r.b  = add_ev(r.b, clt_pkg::EV_ERROR, 32'd0, clt_pkg::ERR_BAD_START);
        end
      end
      clt_pkg::ST_NAME: begin
        if (is_word(c)) begin
          r.b = add_ev(r.b, clt_pkg::EV_NAME_CHAR, 32'(c), clt_pkg::ERR_NONE);
        end else if (is_space(c)) begin
          r.b         = add_ev(r.b, clt_pkg::EV_NAME_END, 32'd0, clt_pkg::ERR_NONE);
          r.nx.pstate = clt_pkg::ST_LIST;
          r.nx.vpend  = 1'b0;
          r.nx.aseen  = 1'b0;
        end else if (c == clt_pkg::CH_SEMI) begin
          r.b  = add_ev(r.b, clt_pkg::EV_NAME_END, 32'd0, clt_pkg::ERR_NONE);
          r.nx = CTX_RESET;
          r.b  = add_ev(r.b, clt_pkg::EV_CMD_END, 32'd0, clt_pkg::ERR_NONE);
        end else begin
          r.nx = CTX_RESET;
          r.b  = add_ev(r.b, clt_pkg::EV_ERROR, 32'd0, clt_pkg::ERR_BAD_NAME);
        end
      end
      clt_pkg::ST_LIST: begin
        r = list_step(s, c, r.b);
      end
      clt_pkg::ST_WORD: begin
        if (is_word(c)) begin
          r.b = add_ev(r.b, clt_pkg::EV_ARG_CHAR, 32'(c), clt_pkg::ERR_NONE);
        end else begin
          t.pstate = clt_pkg::ST_LIST;
          r = list_step(t, c, r.b);
        end
      end
      clt_pkg::ST_STRING: begin
        r = string_step(s, c);
      end
      default: begin
        r.nx = CTX_RESET;
      end
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    res = step(ctx_q, char_code_i);
  end

  // next state
  always_comb begin
    ctx_d = ctx_q;
    if (accept) begin
      ctx_d = res.nx;
    end
  end

  // outputs to the queue
  always_comb begin
    bundle_o = res.b;
    push_o   = accept && (res.b.cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= CTX_RESET;
    end else begin
      ctx_q <= ctx_d;
    end
  end

  `CLT_ASSERT_CLK(a_esc_only_in_string,
    (ctx_q.pstate != clt_pkg::ST_STRING) |-> (ctx_q.esc_mode == clt_pkg::ESC_NONE),
    "escape mode active outside a string")
  `CLT_ASSERT_CLK(a_word_has_value,
    (ctx_q.pstate == clt_pkg::ST_WORD) |-> ctx_q.vpend,
    "word state without a pending argument")

endmodule

`default_nettype wire

FILE: rtl/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// small fifo of per-character event bundles between parser and output stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_line_tokenizer_unit_macros.svh"

module clt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire clt_pkg::bundle_t data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output clt_pkg::bundle_t      data_o,
  input  wire logic             pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  clt_pkg::bundle_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CLT_ASSERT_CLK(a_no_push_when_full, push_i |-> !full_o,
    "parser pushed into a full queue")
  `CLT_ASSERT_CLK(a_count_bound, cnt_q <= CntW'(DEPTH),
    "queue count above depth")

endmodule

`default_nettype wire

FILE: rtl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// output stage: shows the events of one bundle one word at a time
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_line_tokenizer_unit_macros.svh"

module clt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire clt_pkg::bundle_t q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            event_kind_o,
  output logic [31:0]           char_value_o,
  output logic [2:0]            error_code_o,
  output logic                  last_of_run_o
);

  clt_pkg::bundle_t bundle_q;
  clt_pkg::event_t  cur;
  logic             bvalid_q, bvalid_d;
  logic             idx_q, idx_d;
  logic             last, take;

  assign last  = idx_q || (bundle_q.cnt != 2'd2);
  assign take  = bvalid_q && out_ready_i;
  // refill when empty or as the final word of a bundle leaves
  assign pop_o = q_valid_i && (!bvalid_q || (take && last));
  assign cur   = idx_q ? bundle_q.ev1 : bundle_q.ev0;

  always_comb begin
    bvalid_d = bvalid_q;
    idx_d    = idx_q;
    if (take) begin
      if (last) begin
        bvalid_d = 1'b0;
      end else begin
        idx_d = 1'b1;
      end
    end
    if (pop_o) begin
      bvalid_d = 1'b1;
      idx_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= 1'b0;
    end else begin
      bvalid_q <= bvalid_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bundle_q <= q_data_i;
    end
  end

  assign out_valid_o   = bvalid_q;
  assign event_kind_o  = cur.kind;
  assign char_value_o  = cur.value;
  assign error_code_o  = cur.err;
  assign last_of_run_o = last;

  `CLT_ASSERT_CLK(a_second_word_follows, (take && !last) |=> (bvalid_q && idx_q),
    "second event of a character was dropped")

endmodule

`default_nettype wire

FILE: rtl/command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// tokenizer for "name arg, arg, ...;" commands, one code point per word
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o with char_code_i, one unicode code
// point per accepted word. output channel: out_valid_o / out_ready_i with
// event_kind_o, char_value_o, error_code_o and last_of_run_o; a character
// causes zero, one or two event words, last_of_run_o marks the final one.
// the parser takes a character every cycle while the queue is not full and
// writes its events into a queue of DEPTH bundles; the output stage sends
// one event word per cycle while out_ready_i is high. events pass through a
// queue entry, then the output bundle register. throughput is one character
// per cycle while each makes at most one event; one making two events holds
// the output stage for both words. when the receiver stalls the queue fills
// and in_ready_o drops once it holds DEPTH bundles. reset returns the parser
// to the start state and empties the queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer_unit #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [20:0] char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_kind_o,
  output logic [31:0]      char_value_o,
  output logic [2:0]       error_code_o,
  output logic             last_of_run_o
);

  clt_pkg::bundle_t push_data, q_data;
  logic             push, q_full, q_valid, pop;

  clt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .bundle_o    (push_data)
  );

  clt_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  clt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .char_value_o  (char_value_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for command_line_tokenizer_unit: a short table of
// hand-picked characters, then randomly built commands with quoted strings,
// escapes and injected noise. every accepted character runs through a local
// model of the tokenizer whose event words are compared with the block's
// output, while both handshakes idle and stall at random
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam int NumProbes   = 32;
  localparam int RandomChars = 1950;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 16;
  localparam string SimpleEscapes = "abfnrtv";

  typedef struct {
    ev_kind_e    kind;
    logic [31:0] value;
    logic [2:0]  err;
    logic        last;
  } token_ev_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             typed;
    ev_kind_e         kind;
    logic [31:0]      value;
    logic [2:0]       err;
  } probe_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [CharW-1:0] char_code_i = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [2:0]       event_kind_o;
  logic [31:0]      char_value_o;
  logic [2:0]       error_code_o;
  logic             last_of_run_o;

  command_line_tokenizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .char_value_o (char_value_o),
    .error_code_o (error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hand-picked characters; typed rows carry the single event they must cause
  probe_row_t probe_table [NumProbes] = '{
    '{CH_SEMI,          1'b1, EV_ERROR,     32'd0,       ERR_BAD_START},
    '{CharW'(" "),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("a"),      1'b1, EV_NAME_CHAR, 32'("a"),    ERR_NONE},
    '{CharW'("!"),      1'b1, EV_ERROR,     32'd0,       ERR_BAD_NAME},
    '{CharW'("b"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'(" "),      1'b1, EV_NAME_END,  32'd0,       ERR_NONE},
    '{CH_COMMA,         1'b1, EV_ERROR,     32'd0,       ERR_DUP_COMMA},
    '{CharW'("c"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_SEMI,          1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("d"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("\t"),     1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_DQUOTE,        1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_BSLASH,        1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("8"),      1'b1, EV_ARG_CHAR,  32'("8"),    ERR_NONE},
    '{CH_BSLASH,        1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_SEVEN,         1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_SEVEN,         1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_SEVEN,         1'b1, EV_ARG_CHAR,  32'd511,     ERR_NONE},
    '{CH_BSLASH,        1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_LOW_X,         1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("g"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'('h1FFFFF), 1'b1, EV_ARG_CHAR,  32'h1FFFFF,  ERR_NONE},
    '{CH_DQUOTE,        1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("w"),      1'b1, EV_ERROR,     32'd0,       ERR_NEED_COMMA},
    '{CharW'("e"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'(" "),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("w"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CH_COMMA,         1'b1, EV_ARG_END,   32'd0,       ERR_NONE},
    '{CH_SEMI,          1'b1, EV_ERROR,     32'd0,       ERR_COMMA_END},
    '{CharW'("f"),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'(" "),      1'b0, EV_NAME_CHAR, 32'd0,       ERR_NONE},
    '{CharW'("#"),      1'b1, EV_ERROR,     32'd0,       ERR_BAD_LIST}
  };

  // tokenizer model state
  parse_state_e cur_state;
  logic         arg_open;
  logic         list_has_args;
  logic         quote_double;
  logic [3:0]   esc_kind;
  logic [3:0]   esc_count;
  logic [31:0]  esc_acc;

  token_ev_t        step_events [$];
  token_ev_t        due_events [$];
  logic [CharW-1:0] line_q [$];

  int  fail_count     = 0;
  int  chars_sent     = 0;
  int  commands_sent  = 0;
  int  words_checked  = 0;
  int  error_events   = 0;
  int  double_chars   = 0;
  int  stall_left     = 0;
  int  cycle_count    = 0;
  bit  no_idle        = 1'b0;
  bit  hold_off       = 1'b0;

  function automatic bit is_blank(logic [CharW-1:0] c);
    return c == CharW'(" ") || c == CharW'("\t") || c == CharW'("\r") ||
           c == CharW'("\n");
  endfunction

  function automatic bit is_word_char(logic [CharW-1:0] c);
    return (c >= CharW'("a") && c <= CharW'("z")) ||
           (c >= CharW'("A") && c <= CharW'("Z")) ||
           (c >= CH_ZERO && c <= CharW'("9")) || c == CharW'("_");
  endfunction

  function automatic int hex_value(logic [CharW-1:0] c);
    if (c >= CH_ZERO && c <= CharW'("9")) return int'(c - CH_ZERO);
    if (c >= CharW'("a") && c <= CharW'("f")) return int'(c - CharW'("a")) + 10;
    if (c >= CharW'("A") && c <= CharW'("F")) return int'(c - CharW'("A")) + 10;
    return -1;
  endfunction

  function automatic logic [31:0] escape_code(logic [CharW-1:0] c);
    case (c)
      CharW'("a"): return 32'd7;
      CharW'("b"): return 32'd8;
      CharW'("f"): return 32'd12;
      CharW'("n"): return 32'd10;
      CharW'("r"): return 32'd13;
      CharW'("t"): return 32'd9;
      CharW'("v"): return 32'd11;
      default:     return 32'(c);
    endcase
  endfunction

  function automatic void add_event(ev_kind_e k, logic [31:0] v, logic [2:0] e);
    token_ev_t t;
    t.kind  = k;
    t.value = v;
    t.err   = e;
    t.last  = 1'b0;
    step_events.push_back(t);
  endfunction

  function automatic void clear_parser();
    cur_state     = ST_START;
    arg_open      = 1'b0;
    list_has_args = 1'b0;
    quote_double  = 1'b0;
    esc_kind      = ESC_NONE;
    esc_count     = '0;
    esc_acc       = '0;
  endfunction

  function automatic void syntax_error(logic [2:0] code);
    clear_parser();
    add_event(EV_ERROR, 32'd0, code);
  endfunction

  function automatic void list_token(logic [CharW-1:0] c);
    if (c == CH_SEMI) begin
      if (arg_open || !list_has_args) begin
        if (arg_open) add_event(EV_ARG_END, 32'd0, ERR_NONE);
        clear_parser();
        add_event(EV_CMD_END, 32'd0, ERR_NONE);
      end else begin
        syntax_error(ERR_COMMA_END);
      end
    end else if (c == CH_COMMA) begin
      if (arg_open) begin
        add_event(EV_ARG_END, 32'd0, ERR_NONE);
        arg_open      = 1'b0;
        list_has_args = 1'b1;
      end else begin
        syntax_error(ERR_DUP_COMMA);
      end
    end else if (is_blank(c)) begin
      // skipped between arguments
    end else if (arg_open) begin
      syntax_error(ERR_NEED_COMMA);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      arg_open     = 1'b1;
      quote_double = (c == CH_DQUOTE);
      esc_kind     = ESC_NONE;
      esc_count    = '0;
      esc_acc      = '0;
      cur_state    = ST_STRING;
    end else if (is_word_char(c)) begin
      arg_open  = 1'b1;
      cur_state = ST_WORD;
      add_event(EV_ARG_CHAR, 32'(c), ERR_NONE);
    end else begin
      syntax_error(ERR_BAD_LIST);
    end
  endfunction

  // returns 1 when a cut-short escape hands c back as a plain string char
  function automatic bit string_token(logic [CharW-1:0] c);
    int d;
    if (esc_kind == ESC_OCT) begin
      if (c >= CH_ZERO && c <= CH_SEVEN) begin
        esc_acc   = (esc_acc << 3) + 32'(c - CH_ZERO);
        esc_count = esc_count + 4'd1;
        if (esc_count >= OCT_DIGITS) begin
          add_event(EV_ARG_CHAR, esc_acc, ERR_NONE);
          esc_kind = ESC_NONE;
        end
        return 1'b0;
      end
      add_event(EV_ARG_CHAR, esc_acc, ERR_NONE);
      esc_kind = ESC_NONE;
      return 1'b1;
    end
    if (esc_kind >= ESC_HEX2) begin
      d = hex_value(c);
      if (d >= 0) begin
        esc_acc   = (esc_acc << 4) + 32'(d);
        esc_count = esc_count + 4'd1;
        if (esc_count >= esc_kind) begin
          add_event(EV_ARG_CHAR, esc_acc, ERR_NONE);
          esc_kind = ESC_NONE;
        end
        return 1'b0;
      end
      add_event(EV_ARG_CHAR, esc_acc, ERR_NONE);
      esc_kind = ESC_NONE;
      return 1'b1;
    end
    if (esc_kind == ESC_SLASH) begin
      esc_count = '0;
      esc_acc   = '0;
      if (c >= CH_ZERO && c <= CH_SEVEN) begin
        esc_kind  = ESC_OCT;
        esc_count = 4'd1;
        esc_acc   = 32'(c - CH_ZERO);
      end else if (c == CH_LOW_X) begin
        esc_kind = ESC_HEX2;
      end else if (c == CH_LOW_U) begin
        esc_kind = ESC_HEX4;
      end else if (c == CH_UP_U) begin
        esc_kind = ESC_HEX8;
      end else begin
        esc_kind = ESC_NONE;
        add_event(EV_ARG_CHAR, escape_code(c), ERR_NONE);
      end
      return 1'b0;
    end
    if (c == CH_BSLASH) begin
      esc_kind = ESC_SLASH;
    end else if (c == (quote_double ? CH_DQUOTE : CH_SQUOTE)) begin
      cur_state = ST_LIST;
    end else begin
      add_event(EV_ARG_CHAR, 32'(c), ERR_NONE);
    end
    return 1'b0;
  endfunction

  // events caused by one character, left in step_events
  function automatic void tokenize_char(logic [CharW-1:0] c);
    bit again;
    step_events.delete();
    case (cur_state)
      ST_START: begin
        if (is_blank(c)) begin
          // leading blanks are dropped
        end else if (is_word_char(c)) begin
          cur_state = ST_NAME;
          add_event(EV_NAME_CHAR, 32'(c), ERR_NONE);
        end else begin
          syntax_error(ERR_BAD_START);
        end
      end
      ST_NAME: begin
        if (is_word_char(c)) begin
          add_event(EV_NAME_CHAR, 32'(c), ERR_NONE);
        end else if (is_blank(c)) begin
          add_event(EV_NAME_END, 32'd0, ERR_NONE);
          cur_state     = ST_LIST;
          arg_open      = 1'b0;
          list_has_args = 1'b0;
        end else if (c == CH_SEMI) begin
          add_event(EV_NAME_END, 32'd0, ERR_NONE);
          clear_parser();
          add_event(EV_CMD_END, 32'd0, ERR_NONE);
        end else begin
          syntax_error(ERR_BAD_NAME);
        end
      end
      ST_LIST: list_token(c);
      ST_WORD: begin
        if (is_word_char(c)) begin
          add_event(EV_ARG_CHAR, 32'(c), ERR_NONE);
        end else begin
          cur_state = ST_LIST;
          list_token(c);
        end
      end
      ST_STRING: begin
        again = string_token(c);
        if (again) again = string_token(c);
      end
      default: clear_parser();
    endcase
    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
  endfunction

  // ---- stimulus helpers ----

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [CharW-1:0] pick_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return CharW'("a") + CharW'(r);
    if (r < 52) return CharW'("A") + CharW'(r - 26);
    if (r < 62) return CH_ZERO + CharW'(r - 52);
    return CharW'("_");
  endfunction

  function automatic logic [CharW-1:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CharW'("\t");
      1:       return CharW'("\r");
      2:       return CharW'("\n");
      default: return CharW'(" ");
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_any();
    case ($urandom_range(0, 3))
      0, 1:    return CharW'($urandom_range(32, 126));
      2:       return CharW'($urandom_range(0, 255));
      default: return ($urandom_range(0, 7) == 0) ? CharW'('h1FFFFF) : CharW'($urandom);
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return CH_SEMI;
      1:       return CH_COMMA;
      2:       return CH_DQUOTE;
      3:       return CH_SQUOTE;
      4:       return CH_BSLASH;
      default: return pick_any();
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_hex_digit();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return CH_ZERO + CharW'(r);
    return ($urandom_range(0, 1) ? CharW'("a") : CharW'("A")) + CharW'(r - 10);
  endfunction

  function automatic void add_blanks(int n);
    repeat (n) line_q.push_back(pick_blank());
  endfunction

  function automatic void add_word(int n);
    repeat (n) line_q.push_back(pick_word_char());
  endfunction

  function automatic void add_string();
    logic [CharW-1:0] q;
    logic [CharW-1:0] c;
    int               pieces;
    int               ndig;
    int               k;
    bit               all_f;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    line_q.push_back(q);
    pieces = $urandom_range(0, 4);
    for (int i = 0; i < pieces; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          c = pick_any();
          if (c == q || c == CH_BSLASH) c = pick_word_char();
          line_q.push_back(c);
        end
        4: begin
          line_q.push_back(CH_BSLASH);
          if ($urandom_range(0, 1)) line_q.push_back(CharW'(SimpleEscapes[$urandom_range(0, 6)]));
          else line_q.push_back(pick_any());
        end
        5, 6: begin
          line_q.push_back(CH_BSLASH);
          repeat ($urandom_range(1, 3)) line_q.push_back(CH_ZERO + CharW'($urandom_range(0, 7)));
        end
        default: begin
          line_q.push_back(CH_BSLASH);
          case ($urandom_range(0, 2))
            0:       begin line_q.push_back(CH_LOW_X); ndig = 2; end
            1:       begin line_q.push_back(CH_LOW_U); ndig = 4; end
            default: begin line_q.push_back(CH_UP_U);  ndig = 8; end
          endcase
          // sometimes cut short by the next char
          k     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ndig - 1) : ndig;
          all_f = ($urandom_range(0, 5) == 0);
          repeat (k) line_q.push_back(all_f ? CharW'("F") : pick_hex_digit());
        end
      endcase
    end
    line_q.push_back(q);
  endfunction

  // one command, mostly well formed, now and then damaged
  function automatic void build_command();
    int nargs;
    int idx;
    line_q.delete();
    if ($urandom_range(0, 11) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(pick_noise());
    if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
    add_word($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0) begin
      line_q.push_back(CH_SEMI);
    end else begin
      add_blanks($urandom_range(1, 2));
      nargs = $urandom_range(0, 3);
      for (int i = 0; i < nargs; i++) begin
        if (i > 0) begin
          if ($urandom_range(0, 2) == 0) add_blanks(1);
          line_q.push_back(CH_COMMA);
          if ($urandom_range(0, 1) == 0) add_blanks(1);
        end
        if ($urandom_range(0, 1)) add_word($urandom_range(1, 4));
        else add_string();
      end
      if ($urandom_range(0, 2) == 0) add_blanks(1);
      line_q.push_back(CH_SEMI);
    end
    if ($urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, line_q.size() - 1);
      line_q[idx] = pick_noise();
    end
  endfunction

  // offer one word at the falling edge and hold it until taken
  task automatic send_char(input probe_row_t row);
    token_ev_t want;
    int        gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= row.ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tokenize_char(row.ch);
    if (step_events.size() == 2) double_chars++;
    if (row.typed) begin
      want.kind  = row.kind;
      want.value = row.value;
      want.err   = row.err;
      want.last  = 1'b1;
      due_events.push_back(want);
    end else begin
      foreach (step_events[i]) due_events.push_back(step_events[i]);
    end
    chars_sent++;
    @(negedge clk_i);
  endtask

  // ---- receiver ----

  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
      end
    end
  end

  // one long receiver stall so the event queue fills and input ready drops
  initial begin
    wait (chars_sent >= 600);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic void check_word();
    token_ev_t want;
    words_checked++;
    if (event_kind_o == EV_ERROR) error_events++;
    if (due_events.size() == 0) begin
      $error("unexpected event word: kind %0d value %0h", event_kind_o, char_value_o);
      fail_count++;
      return;
    end
    want = due_events.pop_front();
    if (event_kind_o !== want.kind) begin
      $error("event_kind: expected %0d, got %0d", want.kind, event_kind_o);
      fail_count++;
    end
    if (char_value_o !== want.value) begin
      $error("char_value: expected %0h, got %0h", want.value, char_value_o);
      fail_count++;
    end
    if (error_code_o !== want.err) begin
      $error("error_code: expected %0d, got %0d", want.err, error_code_o);
      fail_count++;
    end
    if (last_of_run_o !== want.last) begin
      $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_word();
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---- main sequence ----

  initial begin
    probe_row_t row;
    clear_parser();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumProbes; i++) send_char(probe_table[i]);

    while (chars_sent < NumProbes + RandomChars) begin
      build_command();
      no_idle = (commands_sent % 9 == 4);
      foreach (line_q[i]) begin
        row = '{line_q[i], 1'b0, EV_NAME_CHAR, 32'd0, ERR_NONE};
        send_char(row);
      end
      commands_sent++;
    end
    no_idle    = 1'b0;
    in_valid_i <= 1'b0;

    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d characters over %0d random commands and %0d event words",
             chars_sent, commands_sent, words_checked);
    $display("of which %0d were syntax errors and %0d characters produced two words",
             error_events, double_chars);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

FILE: command_line_tokenizer_unit.f
+incdir+rtl
rtl/clt_pkg.sv
rtl/clt_front.sv
rtl/clt_queue.sv
rtl/clt_back.sv
rtl/command_line_tokenizer_unit.sv
tb/tb.sv
